>>> rtl/adm_pkg.sv
// Shared types, constants and helpers for the arcade drive mixer.
`default_nettype none
package adm_pkg;

	localparam int GEAR_COUNT_DEF = 4;
	localparam int QUEUE_DEPTH    = 2;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 7;

	// floor(m / 10000) == (m * RECIP) >> RECIP_SHIFT for m < 2**25
	localparam logic [24:0] RECIP       = 25'd27487791;
	localparam int          RECIP_SHIFT = 38;

	localparam logic [6:0] DEADZONE_RST = 7'd5;
	localparam logic [6:0] GEAR0_RST    = 7'd10;
	localparam logic [6:0] GEAR1_RST    = 7'd40;
	localparam logic [6:0] GEAR2_RST    = 7'd70;
	localparam logic [6:0] GEAR3_RST    = 7'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADZONE = 3'd0,
		REG_GEAR0    = 3'd1,
		REG_GEAR1    = 3'd2,
		REG_GEAR2    = 3'd3,
		REG_GEAR3    = 3'd4
	} cfg_reg_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic signed [8:0] fwd;
		logic [8:0]        turn_mag;
		logic              turn_neg;
		logic [6:0]        lim;
		logic [1:0]        gear;
		logic              reversed;
		logic              mode;
	} cmd_t;

	function automatic logic signed [7:0] dead_zone(logic signed [7:0] a, logic [6:0] dz);
		logic [7:0] mag;
		mag = a[7] ? 8'(-a) : 8'(a);
		return (mag < {1'b0, dz}) ? 8'sd0 : a;
	endfunction

endpackage
`default_nettype wire

>>> rtl/adm_front.sv
// Front end: configuration registers, deadzone, turn select and button state.
`default_nettype none
module adm_front
	import adm_pkg::*;
#(
	parameter int GEAR_COUNT = GEAR_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic signed [7:0]     forward_axis,
	input  wire logic signed [7:0]     left_turn_axis,
	input  wire logic signed [7:0]     right_turn_axis,
	input  wire logic                  gear_up_button,
	input  wire logic                  gear_down_button,
	input  wire logic                  reverse_button,
	input  wire logic                  mode_button,
	input  wire logic                  q_ready,
	output logic                       q_push,
	output cmd_t                       q_item
);

	localparam logic [1:0] GEAR_TOP = 2'(GEAR_COUNT - 1);
	localparam logic [1:0] GEAR_RST = (GEAR_COUNT - 1 < 2) ? 2'(GEAR_COUNT - 1) : 2'd2;

	logic [6:0] deadzone_q;
	logic [6:0] gear_speed_q [4];
	logic [1:0] gear_q;
	logic       reversed_q;
	logic       mode_q;
	logic       prev_up_q;
	logic       prev_dn_q;
	logic       prev_rev_q;
	logic       prev_mode_q;

	logic signed [7:0] fwd_dz;
	logic signed [7:0] lt_dz;
	logic signed [7:0] rt_dz;
	logic signed [8:0] fwd9;
	logic signed [9:0] turn10;
	logic [1:0]        gear_d;
	logic              reversed_d;
	logic              mode_d;
	logic              accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = !q_ready;
	assign accept    = in_valid && q_ready;
	assign q_push    = accept;

	always_comb begin
		fwd_dz = dead_zone(forward_axis, deadzone_q);
		lt_dz  = dead_zone(left_turn_axis, deadzone_q);
		rt_dz  = dead_zone(right_turn_axis, deadzone_q);
		fwd9   = reversed_q ? -9'(fwd_dz) : 9'(fwd_dz);
		turn10 = mode_q ? (10'(lt_dz) + 10'(rt_dz)) : 10'(rt_dz);

		reversed_d = reversed_q ^ (reverse_button && !prev_rev_q);
		mode_d     = mode_q ^ (mode_button && !prev_mode_q);
		priority if (gear_up_button && !prev_up_q && gear_q < GEAR_TOP) begin
			gear_d = gear_q + 2'd1;
		end else if (gear_down_button && !prev_dn_q && gear_q != 2'd0) begin
			gear_d = gear_q - 2'd1;
		end else begin
			gear_d = gear_q;
		end

		q_item.fwd      = fwd9;
		q_item.turn_neg = turn10[9];
		q_item.turn_mag = turn10[9] ? 9'(-turn10) : 9'(turn10);
		q_item.lim      = gear_speed_q[gear_q];
		q_item.gear     = gear_d;
		q_item.reversed = reversed_d;
		q_item.mode     = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q      <= DEADZONE_RST;
			gear_speed_q[0] <= GEAR0_RST;
			gear_speed_q[1] <= GEAR1_RST;
			gear_speed_q[2] <= GEAR2_RST;
			gear_speed_q[3] <= GEAR3_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEADZONE: deadzone_q      <= cfg_data;
				REG_GEAR0:    gear_speed_q[0] <= cfg_data;
				REG_GEAR1:    gear_speed_q[1] <= cfg_data;
				REG_GEAR2:    gear_speed_q[2] <= cfg_data;
				REG_GEAR3:    gear_speed_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q      <= GEAR_RST;
			reversed_q  <= 1'b0;
			mode_q      <= 1'b0;
			prev_up_q   <= 1'b0;
			prev_dn_q   <= 1'b0;
			prev_rev_q  <= 1'b0;
			prev_mode_q <= 1'b0;
		end else if (accept) begin
			gear_q      <= gear_d;
			reversed_q  <= reversed_d;
			mode_q      <= mode_d;
			prev_up_q   <= gear_up_button;
			prev_dn_q   <= gear_down_button;
			prev_rev_q  <= reverse_button;
			prev_mode_q <= mode_button;
		end
	end

endmodule
`default_nettype wire

>>> rtl/adm_fifo.sv
// Short command queue between front and back.
`default_nettype none
module adm_fifo
	import adm_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_item,
	output logic      ready,
	input  wire logic pop,
	output logic      valid,
	output cmd_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign ready = count_q != CNT_FULL;
	assign valid = count_q != '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/adm_back.sv
// Back end: cubic turn curve on a shared multiplier, mix, gear clamp, output register.
`default_nettype none
module adm_back
	import adm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	input  wire cmd_t         q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic signed [7:0] left_power,
	output logic signed [7:0] right_power,
	output logic              coast,
	output logic [1:0]        gear_now,
	output logic              reversed_now,
	output logic              mode_now
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CUBE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	cmd_t   work_q;
	logic [49:0] prod_q;
	logic        out_valid_q;
	logic signed [7:0] lp_q;
	logic signed [7:0] rp_q;
	logic        coast_q;
	logic [1:0]  gear_q;
	logic        rev_q;
	logic        mode_q;

	logic [24:0] mul_a;
	logic [24:0] mul_b;
	logic [49:0] mul_p;
	logic        fin_go;
	logic [10:0] quo;
	logic signed [11:0] curve;
	logic signed [12:0] twice_fwd;
	logic signed [12:0] sum_l;
	logic signed [12:0] sum_r;
	logic signed [7:0]  lp_d;
	logic signed [7:0]  rp_d;

	function automatic logic signed [7:0] mix_clamp(logic signed [12:0] s, logic [6:0] lim);
		logic signed [12:0] t;
		logic signed [11:0] h;
		logic signed [11:0] limw;
		t    = s + 13'(s[12]);
		h    = t[12:1];
		limw = $signed({5'b0, lim});
		if (h > limw) begin
			return $signed({1'b0, lim});
		end else if (h < -limw) begin
			return -$signed({1'b0, lim});
		end
		return h[7:0];
	endfunction

	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign q_pop  = q_valid && ((state_q == ST_IDLE) || fin_go);

	always_comb begin
		unique case (state_q)
			ST_CUBE: begin
				mul_a = prod_q[24:0];
				mul_b = 25'(work_q.turn_mag);
			end
			ST_DIV: begin
				mul_a = prod_q[24:0];
				mul_b = RECIP;
			end
			default: begin
				mul_a = 25'(q_item.turn_mag);
				mul_b = 25'(q_item.turn_mag);
			end
		endcase
		mul_p = mul_a * mul_b;

		quo       = prod_q[RECIP_SHIFT+10:RECIP_SHIFT];
		curve     = work_q.turn_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		twice_fwd = $signed({{3{work_q.fwd[8]}}, work_q.fwd, 1'b0});
		sum_l     = twice_fwd + 13'(curve);
		sum_r     = twice_fwd - 13'(curve);
		lp_d      = mix_clamp(sum_l, work_q.lim);
		rp_d      = mix_clamp(sum_r, work_q.lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
				lp_q        <= lp_d;
				rp_q        <= rp_d;
				coast_q     <= (lp_d == 8'sd0) && (rp_d == 8'sd0);
				gear_q      <= work_q.gear;
				rev_q       <= work_q.reversed;
				mode_q      <= work_q.mode;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				work_q <= q_item;
			end
			if (q_pop || state_q == ST_CUBE || state_q == ST_DIV) begin
				prod_q <= mul_p;
			end
			unique case (state_q)
				ST_IDLE: if (q_pop) state_q <= ST_CUBE;
				ST_CUBE: state_q <= ST_DIV;
				ST_DIV:  state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= q_pop ? ST_CUBE : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign left_power   = lp_q;
	assign right_power  = rp_q;
	assign coast        = coast_q;
	assign gear_now     = gear_q;
	assign reversed_now = rev_q;
	assign mode_now     = mode_q;

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	a_quotient_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (prod_q[49] == 1'b0))
		else $error("curve quotient overflow");

	a_coast_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (coast_q == ((lp_q == 8'sd0) && (rp_q == 8'sd0))))
		else $error("coast disagrees with powers");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid_q)
		else $error("finished transaction not presented");

endmodule
`default_nettype wire

>>> rtl/arcade_drive_mixer.sv
// Arcade drive mixer top level: front end, command queue and curve/mix back end.
// Each transaction on the input channel is one joystick sample and yields exactly one
// transaction on the output channel, in order. The front end takes a sample in the cycle
// it arrives whenever the two-entry command queue has room, applies the deadzone,
// selects the turn source and updates gear, reverse and mode from button edges. The back
// end shares one 25x25 multiplier for the square, the cube and the reciprocal divide by
// 10000, then mixes and clamps to the gear speed and registers the result. The back end
// takes a new sample only while idle or as it finishes the one before.
// Configuration writes are always ready; write only while the block is idle.
`default_nettype none
module arcade_drive_mixer
	import adm_pkg::*;
#(
	parameter int GEAR_COUNT = GEAR_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic signed [7:0]     forward_axis,
	input  wire logic signed [7:0]     left_turn_axis,
	input  wire logic signed [7:0]     right_turn_axis,
	input  wire logic                  gear_up_button,
	input  wire logic                  gear_down_button,
	input  wire logic                  reverse_button,
	input  wire logic                  mode_button,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [7:0]          left_power,
	output logic signed [7:0]          right_power,
	output logic                       coast,
	output logic [1:0]                 gear_now,
	output logic                       reversed_now,
	output logic                       mode_now
);

	logic q_ready;
	logic q_push;
	logic q_valid;
	logic q_pop;
	cmd_t push_item;
	cmd_t head_item;

	adm_front #(
		.GEAR_COUNT(GEAR_COUNT)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.forward_axis    (forward_axis),
		.left_turn_axis  (left_turn_axis),
		.right_turn_axis (right_turn_axis),
		.gear_up_button  (gear_up_button),
		.gear_down_button(gear_down_button),
		.reverse_button  (reverse_button),
		.mode_button     (mode_button),
		.q_ready         (q_ready),
		.q_push          (q_push),
		.q_item          (push_item)
	);

	adm_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(push_item),
		.ready    (q_ready),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head_item)
	);

	adm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (head_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_power  (left_power),
		.right_power (right_power),
		.coast       (coast),
		.gear_now    (gear_now),
		.reversed_now(reversed_now),
		.mode_now    (mode_now)
	);

endmodule
`default_nettype wire
